/* rtl/tlv8_fragmenting_encoder_defines.svh */
// Assertion macros for the TLV8 encoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TLV8_FRAGMENTING_ENCODER_DEFINES_SVH
`define TLV8_FRAGMENTING_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define TLV8FE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define TLV8FE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tlv8fe_pkg.sv */
// Types, constants and helpers for the TLV8 fragmenting encoder.
// No dependencies; used by every RTL file of the block.
package tlv8fe_pkg;

    localparam int LENGTH_BITS = 16;
    localparam logic [7:0] FRAG_MAX = 8'd255;
    localparam logic [7:0] SEP_BYTE = 8'hFF;
    localparam int MAX_RESULTS = 3;

    typedef logic [LENGTH_BITS-1:0] len_t;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_DATA   = 2'd1,
        MODE_SEP    = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] b;
        logic       done;
        logic       err;
    } result_t;

    // Up to three results produced by one input item.
    typedef struct packed {
        logic [1:0]                   count;
        result_t [MAX_RESULTS-1:0]    r;
    } burst_t;

    function automatic logic [7:0] next_fragment(input len_t remaining);
        if (remaining > len_t'(FRAG_MAX))
            return FRAG_MAX;
        else
            return remaining[7:0];
    endfunction

endpackage

/* rtl/tlv8fe_core.sv */
// Element state and result generation for one input item.
// Depends on tlv8fe_pkg.
module tlv8fe_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [1:0]           mode,
    input  logic [7:0]           elem_type,
    input  logic [15:0]          elem_length,
    input  logic [7:0]           data_byte,
    output tlv8fe_pkg::burst_t   burst
);

    logic               open_reg, open_next;
    logic [7:0]         type_reg, type_next;
    tlv8fe_pkg::len_t   bytes_reg, bytes_next;
    logic [7:0]         frag_reg, frag_next;

    tlv8fe_pkg::len_t   length;
    tlv8fe_pkg::len_t   bytes_dec;
    logic [7:0]         frag_dec;
    logic [7:0]         first_frag;
    logic [7:0]         refill_frag;

    assign length      = tlv8fe_pkg::len_t'(elem_length);
    assign bytes_dec   = bytes_reg - tlv8fe_pkg::len_t'(1);
    assign frag_dec    = frag_reg - 8'd1;
    assign first_frag  = tlv8fe_pkg::next_fragment(length);
    assign refill_frag = tlv8fe_pkg::next_fragment(bytes_dec);

    always_comb
    begin
        open_next  = open_reg;
        type_next  = type_reg;
        bytes_next = bytes_reg;
        frag_next  = frag_reg;
        burst      = '0;
        // default is the single error result
        burst.count    = 2'd1;
        burst.r[0].err = 1'b1;
        case (tlv8fe_pkg::mode_t'(mode))
            tlv8fe_pkg::MODE_HEADER:
            begin
                if (!open_reg)
                begin
                    burst.count     = 2'd2;
                    burst.r[0].err  = 1'b0;
                    burst.r[0].b    = elem_type;
                    burst.r[1].b    = first_frag;
                    burst.r[1].done = (length == '0);
                    if (length != '0)
                    begin
                        open_next  = 1'b1;
                        type_next  = elem_type;
                        bytes_next = length;
                        frag_next  = first_frag;
                    end
                end
            end
            tlv8fe_pkg::MODE_DATA:
            begin
                if (open_reg)
                begin
                    burst.r[0].err = 1'b0;
                    burst.r[0].b   = data_byte;
                    bytes_next     = bytes_dec;
                    frag_next      = frag_dec;
                    if (bytes_dec == '0)
                    begin
                        burst.r[0].done = 1'b1;
                        open_next       = 1'b0;
                        frag_next       = 8'd0;
                    end
                    else if (frag_dec == 8'd0)
                    begin
                        // fragment full: insert type and next length
                        burst.count  = 2'd3;
                        burst.r[1].b = type_reg;
                        burst.r[2].b = refill_frag;
                        frag_next    = refill_frag;
                    end
                end
            end
            tlv8fe_pkg::MODE_SEP:
            begin
                if (!open_reg)
                begin
                    burst.count     = 2'd2;
                    burst.r[0].err  = 1'b0;
                    burst.r[0].b    = tlv8fe_pkg::SEP_BYTE;
                    burst.r[1].b    = 8'h00;
                    burst.r[1].done = 1'b1;
                end
            end
            default:
            begin
                burst.count    = 2'd1;
                burst.r[0].err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            type_reg  <= 8'd0;
            bytes_reg <= '0;
            frag_reg  <= 8'd0;
        end
        else if (fire)
        begin
            open_reg  <= open_next;
            type_reg  <= type_next;
            bytes_reg <= bytes_next;
            frag_reg  <= frag_next;
        end
    end

endmodule

/* rtl/tlv8fe_outq.sv */
// Result register: holds one item's results and hands them out one per transfer.
// Depends on tlv8fe_pkg and tlv8_fragmenting_encoder_defines.svh.
`include "tlv8_fragmenting_encoder_defines.svh"

module tlv8fe_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  tlv8fe_pkg::burst_t   burst,
    output logic                 can_load,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 run_last,
    output logic                 element_done,
    output logic                 error
);

    tlv8fe_pkg::burst_t burst_reg;
    logic               full_reg;
    logic [1:0]         idx_reg;
    tlv8fe_pkg::result_t cur;
    logic               last;
    logic               take;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = burst_reg.r[0];
            2'd1:    cur = burst_reg.r[1];
            2'd2:    cur = burst_reg.r[2];
            default: cur = burst_reg.r[0];
        endcase
    end

    assign last         = (idx_reg == burst_reg.count - 2'd1);
    assign take         = full_reg && out_ready;
    // accept a new item while the final result of the held one leaves
    assign can_load     = !full_reg || (out_ready && last);
    assign out_valid    = full_reg;
    assign out_byte     = cur.err ? 8'd0 : cur.b;
    assign run_last     = last;
    assign element_done = cur.done;
    assign error        = cur.err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            full_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (take)
        begin
            if (last)
                full_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            burst_reg <= burst;
    end

    `TLV8FE_ASSERT_NOW(a_idx_in_range, full_reg, idx_reg < burst_reg.count, "result index past count")
    `TLV8FE_ASSERT_NEXT(a_load_restarts, load, full_reg && idx_reg == 2'd0, "load did not restart")
    `TLV8FE_ASSERT_NOW(a_error_single, full_reg && burst_reg.r[0].err, burst_reg.count == 2'd1, "error burst not single")
    `TLV8FE_ASSERT_NEXT(a_hold_midburst, take && !last, full_reg, "burst dropped before last")

endmodule

/* rtl/tlv8_fragmenting_encoder.sv */
// TLV8 fragmenting encoder: first result valid in the cycle after an item is accepted.
// An item yielding N results (1 to 3) occupies the output for N transfers; the
// next item is taken in the cycle the last one leaves, so data bytes run one per cycle while out_ready stays high.
// Rate is set by the single result register and its one-byte-per-transfer port.
// Reset (rst_n low, asynchronous) closes any open element and empties the output.
module tlv8_fragmenting_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  elem_type,
    input  logic [15:0] elem_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        element_done,
    output logic        error
);

    tlv8fe_pkg::burst_t burst;
    logic               can_load;
    logic               fire;

    assign in_ready = can_load;
    assign fire     = in_valid && can_load;

    tlv8fe_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .mode        (mode),
        .elem_type   (elem_type),
        .elem_length (elem_length),
        .data_byte   (data_byte),
        .burst       (burst)
    );

    tlv8fe_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .burst        (burst),
        .can_load     (can_load),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .element_done (element_done),
        .error        (error)
    );

endmodule

/* tb/tlv8_fragmenting_encoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for tlv8_fragmenting_encoder: predicts the TLV8 byte stream
// for every accepted item and checks each output transfer in order.
// Depends on tlv8fe_pkg and the encoder RTL.
module tlv8_fragmenting_encoder_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_PCT = 28;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       done;
        logic       err;
    } stream_byte_t;

    class tlv8_stream_scoreboard;
        stream_byte_t       expected_bytes[$];
        logic               elem_open;
        logic [7:0]         open_type;
        tlv8fe_pkg::len_t   bytes_left;
        logic [7:0]         frag_left;
        int                 mismatches;

        function new();
            elem_open  = 1'b0;
            open_type  = '0;
            bytes_left = '0;
            frag_left  = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Work out the bytes one accepted item produces and queue them.
        function void take_item(logic [1:0] m, logic [7:0] t, logic [15:0] len,
                                logic [7:0] d);
            stream_byte_t       burst[$];
            stream_byte_t       b;
            logic [7:0]         frag;
            tlv8fe_pkg::len_t   length;
            length = tlv8fe_pkg::len_t'(len);
            if (m == tlv8fe_pkg::MODE_HEADER && !elem_open) begin
                frag = (length > tlv8fe_pkg::len_t'(tlv8fe_pkg::FRAG_MAX)) ?
                       tlv8fe_pkg::FRAG_MAX : length[7:0];
                burst.push_back('{t, 1'b0, 1'b0, 1'b0});
                burst.push_back('{frag, 1'b0, (length == 0), 1'b0});
                if (length != 0)
                begin
                    elem_open  = 1'b1;
                    open_type  = t;
                    bytes_left = length;
                    frag_left  = frag;
                end
            end
            else if (m == tlv8fe_pkg::MODE_DATA && elem_open)
            begin
                bytes_left = bytes_left - 1'b1;
                frag_left  = frag_left - 1'b1;
                if (bytes_left == 0)
                begin
                    burst.push_back('{d, 1'b0, 1'b1, 1'b0});
                    elem_open = 1'b0;
                    frag_left = '0;
                end
                else
                begin
                    burst.push_back('{d, 1'b0, 1'b0, 1'b0});
                    // fragment full with bytes still to come: insert a fresh header
                    if (frag_left == 0)
                    begin
                        frag = (bytes_left > tlv8fe_pkg::len_t'(tlv8fe_pkg::FRAG_MAX)) ?
                               tlv8fe_pkg::FRAG_MAX : bytes_left[7:0];
                        burst.push_back('{open_type, 1'b0, 1'b0, 1'b0});
                        burst.push_back('{frag, 1'b0, 1'b0, 1'b0});
                        frag_left = frag;
                    end
                end
            end
            else if (m == tlv8fe_pkg::MODE_SEP && !elem_open)
            begin
                burst.push_back('{tlv8fe_pkg::SEP_BYTE, 1'b0, 1'b0, 1'b0});
                burst.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
            end
            else
            begin
                burst.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
            end
            for (int i = 0; i < burst.size(); i++)
            begin
                b = burst[i];
                b.last = (i == burst.size() - 1);
                expected_bytes.push_back(b);
            end
        endfunction

        function void check_byte(logic [7:0] value, logic last, logic done, logic err);
            stream_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected output transfer: out_byte %0h", value);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (value !== want.value)
            begin
                $error("out_byte expected %0h actual %0h", want.value, value);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("run_last expected %0b actual %0b", want.last, last);
                mismatches++;
            end
            if (done !== want.done)
            begin
                $error("element_done expected %0b actual %0b", want.done, done);
                mismatches++;
            end
            if (err !== want.err)
            begin
                $error("error expected %0b actual %0b", want.err, err);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [7:0]  elem_type;
    logic [15:0] elem_length;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        element_done;
    logic        error;

    logic steady;
    int   items_sent;

    tlv8_stream_scoreboard sb = new();

    tlv8_fragmenting_encoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .elem_type    (elem_type),
        .elem_length  (elem_length),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .element_done (element_done),
        .error        (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Present one item and hold it until the transfer happens.
    task automatic send_item(input logic [1:0] m, input logic [7:0] t,
                             input logic [15:0] len, input logic [7:0] d);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        elem_type   <= t;
        elem_length <= len;
        data_byte   <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.take_item(m, t, len, d);
        items_sent++;
    endtask

    task automatic send_header(input logic [7:0] t, input logic [15:0] len);
        send_item(tlv8fe_pkg::MODE_HEADER, t, len, 8'($urandom));
    endtask

    task automatic send_data(input logic [7:0] d);
        send_item(tlv8fe_pkg::MODE_DATA, 8'($urandom), 16'($urandom), d);
    endtask

    task automatic send_separator();
        send_item(tlv8fe_pkg::MODE_SEP, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic send_unused_mode();
        send_item(MODE_UNUSED, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic send_element(input logic [7:0] t, input logic [15:0] len);
        send_header(t, len);
        for (int i = 0; i < int'(len); i++) send_data(8'($urandom));
    endtask

    // Hold the sender until the output has caught up completely.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic random_traffic(input int target);
        int          first;
        int          pick;
        logic [15:0] len;
        first = items_sent;
        while (items_sent - first < target)
        begin
            // open with a stretch free of gaps and stalls
            steady = (items_sent - first < 40);
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    len = 16'd0;
                else if (pick < 75)
                    len = 16'($urandom_range(1, 8));
                else
                    len = 16'($urandom_range(9, 16));
                send_header(8'($urandom), len);
                for (int i = 0; i < int'(len); i++)
                begin
                    // now and then break the order mid-element
                    pick = $urandom_range(0, 99);
                    if (pick < 2)
                        send_header(8'($urandom), 16'($urandom));
                    else if (pick < 4)
                        send_separator();
                    else if (pick < 5)
                        send_unused_mode();
                    send_data(8'($urandom));
                end
                if ($urandom_range(0, 2) == 0)
                    send_separator();
            end
            else if (pick < 85)
                send_data(8'($urandom));
            else if (pick < 92)
                send_unused_mode();
            else
                send_separator();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_byte(out_byte, run_last, element_done, error);
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        #20_000_000;
        $display("tlv8_fragmenting_encoder_tb: FAIL");
        $finish;
    end

    initial
    begin
        steady      = 1'b0;
        items_sent  = 0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= tlv8fe_pkg::MODE_HEADER;
        elem_type   <= 8'h00;
        elem_length <= 16'h0000;
        data_byte   <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: separators, empty elements and every out-of-order case
        send_separator();
        send_header(8'hFF, 16'h0000);
        send_header(8'h00, 16'h0000);
        send_data(8'hFF);
        send_item(MODE_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
        send_header(8'hA5, 16'd3);
        send_data(8'h00);
        send_separator();
        send_header(8'h3C, 16'hFFFF);
        send_item(MODE_UNUSED, 8'h00, 16'h0000, 8'h00);
        send_data(8'hFF);
        send_data(8'h5A);
        send_data(8'h77);
        send_element(8'h01, 16'd1);
        send_separator();
        send_separator();
        send_element(8'h7E, 16'd4);
        drain();

        random_traffic(125);

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tlv8_fragmenting_encoder_tb: PASS");
        else
            $display("tlv8_fragmenting_encoder_tb: FAIL");
        $finish;
    end

endmodule
